// ===== design/egsd_pkg.sv =====
package egsd_pkg;

  // Fixed field widths
  localparam int unsigned IN_BITS    = 8;
  localparam int unsigned VALUE_BITS = 32;
  localparam int unsigned CNT_W      = 4;
  localparam int unsigned ZR_W       = 6;
  localparam int unsigned ST_W       = 2;

  // Result status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_TRUNC = 2'd1;
  localparam logic [ST_W-1:0] ST_LONG  = 2'd2;

  typedef struct packed {
    logic [IN_BITS-1:0] code_bits;
    logic [CNT_W-1:0]   bit_count;
    logic               end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] decoded_value;
    logic [ST_W-1:0]       status;
    logic                  last_in_run;
  } out_item_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_BITS,
    S_EOS,
    S_FLUSH
  } egsd_state_e;

endpackage

// ===== design/elias_gamma_stream_decoder_top.sv =====
// Channel | Direction | Handshake               | Payload
// in      | input     | in_valid_i / in_stall_o  | egsd_pkg::in_item_t
// out     | output    | out_valid_o / out_stall_i| egsd_pkg::out_item_t
//
// One code bit is decoded per cycle, while the output can take results, by a
// single shift/compare step unit; the input stays stalled from the item's
// acceptance through its bits, the end-of-stream check and the flush.
// Each finished value waits in a holding register until the next one or the end
// of the item shows whether it is the last of the item, then moves to the
// output register. Reset clears all decoder state; no clearing pass is needed.
module elias_gamma_stream_decoder_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  egsd_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output egsd_pkg::out_item_t out_item_o
);
  import egsd_pkg::*;

  egsd_state_e state_q, state_d;

  // Captured item
  logic [IN_BITS-1:0] bits_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               eos_q;

  // Decoder state
  logic                  in_payload_q, in_payload_d;
  logic [ZR_W-1:0]       zero_run_q, zero_run_d;
  logic [ZR_W-1:0]       bits_left_q, bits_left_d;
  logic [VALUE_BITS-1:0] acc_q, acc_d;

  // Holding and output registers
  logic                  pend_valid_q;
  logic [VALUE_BITS-1:0] pend_value_q;
  logic [ST_W-1:0]       pend_status_q;
  logic                  out_valid_q;
  out_item_t             out_q;

  // Control strobes
  logic out_free, can_emit;
  logic accept, do_bit, do_eos, do_flush;

  // Step results
  logic                  res_vld;
  logic [VALUE_BITS-1:0] res_val;
  logic [ST_W-1:0]       res_st;
  logic                  clr;
  logic                  cur_bit;
  logic [CNT_W-1:0]      cnt_sat;

  assign out_free = !out_valid_q || !out_stall_i;
  assign can_emit = !pend_valid_q || out_free;
  assign cur_bit  = bits_q[IN_BITS-1];
  assign cnt_sat  = (in_item_i.bit_count > CNT_W'(IN_BITS)) ? CNT_W'(IN_BITS)
                                                             : in_item_i.bit_count;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_BITS;
      S_BITS:  if (cnt_q == '0) state_d = S_EOS;
      S_EOS:   if (can_emit) state_d = S_FLUSH;
      S_FLUSH: if (can_emit) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stall_o = 1'b1;
    accept     = 1'b0;
    do_bit     = 1'b0;
    do_eos     = 1'b0;
    do_flush   = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        accept     = in_valid_i;
      end
      S_BITS:  do_bit   = (cnt_q != '0) && can_emit;
      S_EOS:   do_eos   = can_emit;
      S_FLUSH: do_flush = can_emit;
      default: ;
    endcase
  end

  // Shared step unit: one code bit, or the end-of-stream check
  always_comb begin
    in_payload_d = in_payload_q;
    zero_run_d   = zero_run_q;
    bits_left_d  = bits_left_q;
    acc_d        = acc_q;
    res_vld      = 1'b0;
    res_val      = '0;
    res_st       = ST_OK;
    clr          = 1'b0;
    if (do_bit) begin
      if (!in_payload_q) begin
        if (!cur_bit) begin
          if (zero_run_q == ZR_W'(VALUE_BITS - 1)) begin
            res_vld = 1'b1;
            res_st  = ST_LONG;
            clr     = 1'b1;
          end else begin
            zero_run_d = zero_run_q + ZR_W'(1);
          end
        end else if (zero_run_q == '0) begin
          res_vld = 1'b1;
          res_val = VALUE_BITS'(1);
          clr     = 1'b1;
        end else begin
          acc_d        = VALUE_BITS'(1);
          bits_left_d  = zero_run_q;
          zero_run_d   = '0;
          in_payload_d = 1'b1;
        end
      end else begin
        acc_d       = {acc_q[VALUE_BITS-2:0], cur_bit};
        bits_left_d = bits_left_q - ZR_W'(1);
        if (bits_left_q == ZR_W'(1)) begin
          res_vld = 1'b1;
          res_val = acc_d;
          clr     = 1'b1;
        end
      end
    end else if (do_eos && eos_q && (in_payload_q || zero_run_q != '0)) begin
      res_vld = 1'b1;
      res_st  = ST_TRUNC;
      clr     = 1'b1;
    end
    if (clr) begin
      in_payload_d = 1'b0;
      zero_run_d   = '0;
      bits_left_d  = '0;
      acc_d        = '0;
    end
  end

  // Control and decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_q        <= '0;
      in_payload_q <= 1'b0;
      zero_run_q   <= '0;
      bits_left_q  <= '0;
      acc_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        cnt_q <= cnt_sat;
      end else if (do_bit) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
      if (do_bit || do_eos) begin
        in_payload_q <= in_payload_d;
        zero_run_q   <= zero_run_d;
        bits_left_q  <= bits_left_d;
        acc_q        <= acc_d;
      end
      // holding register moves on when a newer result arrives or the item ends
      if (res_vld) begin
        pend_valid_q <= 1'b1;
      end else if (do_flush) begin
        pend_valid_q <= 1'b0;
      end
      if ((res_vld || do_flush) && pend_valid_q) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      bits_q <= in_item_i.code_bits;
      eos_q  <= in_item_i.end_of_stream;
    end else if (do_bit) begin
      bits_q <= {bits_q[IN_BITS-2:0], 1'b0};
    end
    if (res_vld) begin
      pend_value_q  <= res_val;
      pend_status_q <= res_st;
    end
    if ((res_vld || do_flush) && pend_valid_q) begin
      out_q.decoded_value <= pend_value_q;
      out_q.status        <= pend_status_q;
      out_q.last_in_run   <= do_flush;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Checks
  a_payload_has_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_payload_q |-> (bits_left_q != '0) && (zero_run_q == '0))
    else $error("payload phase with no bits left or a zero run");

  a_count_phase_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_payload_q |-> bits_left_q == '0)
    else $error("bits left while counting zeros");

  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !pend_valid_q)
    else $error("result still held when next item may enter");

  a_error_zero_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.status != ST_OK) |-> out_item_o.decoded_value == '0)
    else $error("error result with nonzero value");

  a_no_step_on_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld && pend_valid_q |-> !out_valid_q || !out_stall_i)
    else $error("result moved into a blocked output register");

endmodule
